// ----- src/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Holds operation and status codes, the per-cell control beat struct
// and the default sizes. No dependencies.
package deq_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned OP_BITS   = 3;
  localparam int unsigned ST_BITS   = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4
  } deq_op_e;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  typedef struct packed {
    logic shift_r;   // push front: every cell takes its left neighbor
    logic shift_l;   // pop front: every cell takes its right neighbor
    logic wr_rear;   // push rear: the cell at the fill level takes the word
  } deq_ctl_t;

endpackage

// ----- src/deq_cell.sv -----
// One storage cell of the queue chain.
// Holds one word and trades it with its neighbors on shifts.
// Depends on deq_pkg for the control struct.
module deq_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned WORD_BITS = deq_pkg::WORD_BITS,
  parameter int unsigned CNT_BITS  = 7
) (
  input  logic                 clk_i,
  input  deq_pkg::deq_ctl_t    ctl_i,
  input  logic [CNT_BITS-1:0]  cnt_i,
  input  logic [WORD_BITS-1:0] push_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] data_o,
  output logic                 last_o,
  output logic                 pen_o
);

  localparam logic [CNT_BITS-1:0] MyPos   = CNT_BITS'(IDX);
  localparam logic [CNT_BITS-1:0] LastCnt = CNT_BITS'(IDX + 1);
  localparam logic [CNT_BITS-1:0] PenCnt  = CNT_BITS'(IDX + 2);

  logic [WORD_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_r) begin
      data_d = left_i;
    end else if (ctl_i.shift_l) begin
      data_d = right_i;
    end else if (ctl_i.wr_rear && (cnt_i == MyPos)) begin
      data_d = push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign last_o = (cnt_i == LastCnt);
  assign pen_o  = (cnt_i == PenCnt);

endmodule

// ----- src/double_ended_queue.sv -----
// Double-ended queue top level: a row of word cells plus count and result register.
// Depends on deq_pkg and deq_cell.
//
// Every request beat (op on tuser, push word on tdata) updates the queue as it
// is taken and yields one registered result beat; a new request is taken in
// every cycle that the result register is free or being drained. The front word
// always sits in cell 0 and the rear word in the cell just below the fill level,
// so a push or pop at the front shifts the whole cell row by one place in that
// cycle, while a push at the rear writes the single cell at the fill level. A push
// when full or a pop when empty returns a status code and leaves the queue
// unchanged. Unknown op codes act as a peek. Cell contents need no clearing after
// reset.
module double_ended_queue #(
  parameter int unsigned CAPACITY  = deq_pkg::CAPACITY,
  parameter int unsigned WORD_BITS = deq_pkg::WORD_BITS,
  localparam int unsigned CntBits  = $clog2(CAPACITY + 1),
  localparam int unsigned InBits   = ((WORD_BITS + 7) / 8) * 8,
  localparam int unsigned OutRaw   = 3 * WORD_BITS + CntBits + 1,
  localparam int unsigned OutBits  = ((OutRaw + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [InBits-1:0]           s_axis_tdata,  // push_value
  input  logic [deq_pkg::OP_BITS-1:0] s_axis_tuser,  // op
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // popped_value, front_value, rear_value, occupancy, is_empty
  output logic [OutBits-1:0]          m_axis_tdata,
  output logic [deq_pkg::ST_BITS-1:0] m_axis_tuser   // status
);

  localparam logic [CntBits-1:0] FullCnt = CntBits'(CAPACITY);
  localparam logic [CntBits-1:0] OneCnt  = CntBits'(1);

  logic                 in_acc;
  logic [WORD_BITS-1:0] push_val;
  deq_pkg::deq_op_e     op;

  logic [CntBits-1:0]   cnt_q, cnt_d;
  deq_pkg::deq_ctl_t    ctl, ctl_act;

  logic [WORD_BITS-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]  cell_last, cell_pen;
  logic [WORD_BITS-1:0] rear_cur, pen_cur, front_cur;

  logic                 full, empty, more;
  deq_pkg::deq_status_e st_res;
  logic [WORD_BITS-1:0] pop_res, front_res, rear_res;

  logic                 out_vld_q;
  logic [OutBits-1:0]   out_data_q;
  deq_pkg::deq_status_e out_st_q;

  assign push_val      = s_axis_tdata[WORD_BITS-1:0];
  assign op            = deq_pkg::deq_op_e'(s_axis_tuser);
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = push_val;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    deq_cell #(
      .IDX       (i),
      .WORD_BITS (WORD_BITS),
      .CNT_BITS  (CntBits)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_act),
      .cnt_i   (cnt_q),
      .push_i  (push_val),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .last_o  (cell_last[i]),
      .pen_o   (cell_pen[i])
    );
  end

  always_comb begin
    rear_cur = '0;
    pen_cur  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rear_cur = rear_cur | (cell_data[i] & {WORD_BITS{cell_last[i]}});
      pen_cur  = pen_cur  | (cell_data[i] & {WORD_BITS{cell_pen[i]}});
    end
  end

  assign front_cur = cell_data[0];
  assign full      = (cnt_q == FullCnt);
  assign empty     = (cnt_q == '0);
  assign more      = (cnt_q > OneCnt);

  always_comb begin
    ctl       = '0;
    cnt_d     = cnt_q;
    pop_res   = '0;
    st_res    = empty ? deq_pkg::ST_EMPTY : deq_pkg::ST_OK;
    front_res = empty ? '0 : front_cur;
    rear_res  = empty ? '0 : rear_cur;
    case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st_res = deq_pkg::ST_FULL;
        end else begin
          ctl.shift_r = 1'b1;
          cnt_d       = cnt_q + OneCnt;
          st_res      = deq_pkg::ST_OK;
          front_res   = push_val;
          rear_res    = empty ? push_val : rear_cur;
        end
      end
      deq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          st_res = deq_pkg::ST_FULL;
        end else begin
          ctl.wr_rear = 1'b1;
          cnt_d       = cnt_q + OneCnt;
          st_res      = deq_pkg::ST_OK;
          rear_res    = push_val;
          front_res   = empty ? push_val : front_cur;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          ctl.shift_l = 1'b1;
          cnt_d       = cnt_q - OneCnt;
          pop_res     = front_cur;
          front_res   = more ? cell_data[1] : '0;
          rear_res    = more ? rear_cur : '0;
        end
      end
      deq_pkg::OP_POP_REAR: begin
        if (!empty) begin
          cnt_d     = cnt_q - OneCnt;
          pop_res   = rear_cur;
          front_res = more ? front_cur : '0;
          rear_res  = more ? pen_cur : '0;
        end
      end
      default: begin
      end
    endcase
    ctl_act = in_acc ? ctl : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_st_q   <= st_res;
      out_data_q <= OutBits'({(cnt_d == '0), cnt_d, rear_res, front_res, pop_res});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_st_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("fill level beyond capacity");

  a_pop_front_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == deq_pkg::OP_POP_FRONT && more)
      |=> (cell_data[0] == $past(cell_data[1])))
    else $error("pop front did not advance the row");

  a_push_rear_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == deq_pkg::OP_PUSH_REAR && !full)
      |=> (rear_cur == $past(push_val)))
    else $error("push rear word not at rear");

  a_result_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (m_axis_tdata[OutRaw-1] == (out_data_q[OutRaw-2 -: CntBits] == '0)))
    else $error("empty flag disagrees with occupancy");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for double_ended_queue: drives request beats, predicts each result beat
// with a ring-store model and compares the results field by field.
// Depends on deq_pkg and the double_ended_queue RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WB         = deq_pkg::WORD_BITS;
  localparam int unsigned CAP        = deq_pkg::CAPACITY;
  localparam int unsigned CNT_W      = $clog2(CAP + 1);
  localparam int unsigned IN_W       = ((WB + 7) / 8) * 8;
  localparam int unsigned OUT_W      = ((3 * WB + CNT_W + 1 + 7) / 8) * 8;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned RAND_ITEMS = 800;

  typedef struct {
    deq_pkg::deq_status_e status;
    logic [WB-1:0]        popped;
    logic [WB-1:0]        front;
    logic [WB-1:0]        rear;
    logic [CNT_W-1:0]     occupancy;
    logic                 is_empty;
  } deq_result_t;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} burst_mode_e;

  class deque_scoreboard;
    logic [WB-1:0] ring [CAP];
    int unsigned   head;
    int unsigned   fill;
    deq_result_t   expected_q [$];
    int unsigned   errors;
    int unsigned   seen;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
      seen   = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [deq_pkg::OP_BITS-1:0] op, logic [WB-1:0] word);
      deq_result_t r;
      r.status = deq_pkg::ST_OK;
      r.popped = '0;
      case (op)
        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
          if (fill == CAP) begin
            r.status = deq_pkg::ST_FULL;
          end else if (op == deq_pkg::OP_PUSH_FRONT) begin
            head = (head + CAP - 1) % CAP;
            ring[head] = word;
            fill++;
          end else begin
            ring[(head + fill) % CAP] = word;
            fill++;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (fill == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            r.popped = ring[head];
            fill--;
            if (fill != 0) head = (head + 1) % CAP;
          end
        end
        deq_pkg::OP_POP_REAR: begin
          if (fill == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            r.popped = ring[(head + fill - 1) % CAP];
            fill--;
          end
        end
        default: begin
          if (fill == 0) r.status = deq_pkg::ST_EMPTY;
        end
      endcase
      r.front     = (fill != 0) ? ring[head] : '0;
      r.rear      = (fill != 0) ? ring[(head + fill - 1) % CAP] : '0;
      r.occupancy = CNT_W'(fill);
      r.is_empty  = (fill == 0);
      expected_q.push_back(r);
    endfunction

    function void compare(string what, logic [WB-1:0] want, logic [WB-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d, %s: expected %h, got %h", seen, what, want, got);
      end
    endfunction

    function void check_result(logic [deq_pkg::ST_BITS-1:0] st, logic [OUT_W-1:0] data);
      deq_result_t r;
      seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %0d arrived with no request pending", seen);
        return;
      end
      r = expected_q.pop_front();
      compare("status", WB'(r.status), WB'(st));
      compare("popped_value", r.popped, data[WB-1:0]);
      compare("front_value", r.front, data[2*WB-1:WB]);
      compare("rear_value", r.rear, data[3*WB-1:2*WB]);
      compare("occupancy", WB'(r.occupancy), WB'(data[3*WB+CNT_W-1:3*WB]));
      compare("is_empty", WB'(r.is_empty), WB'(data[3*WB+CNT_W]));
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [IN_W-1:0]              s_axis_tdata;
  logic [deq_pkg::OP_BITS-1:0]  s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [OUT_W-1:0]             m_axis_tdata;
  logic [deq_pkg::ST_BITS-1:0]  m_axis_tuser;

  deque_scoreboard sb = new();
  int unsigned     src_idle_pct  = 0;
  int unsigned     snk_stall_pct = 0;
  int unsigned     stall_hold    = 0;
  int unsigned     cycles        = 0;

  double_ended_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver: long hold-off first, then random stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_hold > 0) begin
        m_axis_tready <= 1'b0;
        stall_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  task automatic send_request(logic [deq_pkg::OP_BITS-1:0] op, logic [WB-1:0] word);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(word);
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, word);
  endtask

  function automatic logic [WB-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return {1'b0, {(WB-1){1'b1}}};
      2:       return {1'b1, {(WB-1){1'b0}}};
      3:       return '1;
      default: return WB'($urandom);
    endcase
  endfunction

  function automatic logic [deq_pkg::OP_BITS-1:0] pick_op(burst_mode_e mode);
    if (mode != MODE_MIXED && $urandom_range(99) < 85) begin
      if (mode == MODE_GROW)
        return $urandom_range(1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
      return $urandom_range(1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
    end
    return deq_pkg::OP_BITS'($urandom_range(7));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned burst_no;
    burst_mode_e mode;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = deq_pkg::OP_PEEK;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty queue, extreme words, unused codes, last word leaving either end
    send_request(deq_pkg::OP_PEEK, '0);
    send_request(deq_pkg::OP_POP_FRONT, '0);
    send_request(deq_pkg::OP_POP_REAR, '1);
    send_request(3'd5, '0);
    send_request(deq_pkg::OP_PUSH_FRONT, {1'b0, {(WB-1){1'b1}}});
    send_request(deq_pkg::OP_PUSH_REAR, {1'b1, {(WB-1){1'b0}}});
    send_request(deq_pkg::OP_PUSH_FRONT, '0);
    send_request(deq_pkg::OP_PUSH_REAR, '1);
    send_request(deq_pkg::OP_PEEK, '1);
    send_request(3'd6, '1);
    send_request(3'd7, '0);
    send_request(deq_pkg::OP_POP_FRONT, '0);
    send_request(deq_pkg::OP_POP_REAR, '0);
    send_request(deq_pkg::OP_POP_FRONT, '0);
    send_request(deq_pkg::OP_POP_REAR, '0);
    send_request(deq_pkg::OP_POP_REAR, '0);
    send_request(deq_pkg::OP_PEEK, '0);
    send_request(deq_pkg::OP_PUSH_REAR, 32'h5555_5555);
    send_request(deq_pkg::OP_POP_FRONT, '0);
    send_request(deq_pkg::OP_PUSH_FRONT, 32'haaaa_aaaa);
    send_request(deq_pkg::OP_POP_REAR, '0);
    send_request(deq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
    send_request(deq_pkg::OP_POP_FRONT, '0);

    sent       = 0;
    burst_no   = 0;
    stall_hold = 300;
    while (sent < RAND_ITEMS) begin
      case (sent * 4 / RAND_ITEMS)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      case (burst_no % 3)
        0:       mode = MODE_GROW;
        1:       mode = MODE_SHRINK;
        default: mode = MODE_MIXED;
      endcase
      burst_len = (mode == MODE_MIXED) ? $urandom_range(20, 50) : $urandom_range(75, 100);
      if (burst_len > RAND_ITEMS - sent) burst_len = RAND_ITEMS - sent;
      repeat (burst_len) begin
        send_request(pick_op(mode), pick_word());
        sent++;
      end
      burst_no++;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
